// ===== hw/rtl/cmdtok_pkg.sv =====
// ----------------------------------------------------------------------------
// cmdtok_pkg
// shared limits, result and state types for the command line tokenizer
// ----------------------------------------------------------------------------
package cmdtok_pkg;

  localparam int unsigned MAX_COMMAND_BYTES = 32767;
  localparam int unsigned MAX_ARGS          = 128;
  localparam int unsigned MAX_ARG_BYTES     = 4096;

  // results one item can cause, and the counter that holds 0..NRES
  localparam int unsigned NRES  = 4;
  localparam int unsigned IDX_W = $clog2(NRES);
  localparam int unsigned CNT_W = $clog2(NRES + 1);

  localparam int unsigned PEND_W    = 15;
  localparam int unsigned ARGLEN_W  = 16;
  localparam int unsigned ARGCNT_W  = 8;
  // byte count saturates one above the command limit
  localparam int unsigned BYTECNT_W = $clog2(MAX_COMMAND_BYTES + 2);

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    KIND_RUN    = 2'd0,
    KIND_END    = 2'd1,
    KIND_ACCEPT = 2'd2,
    KIND_REJECT = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TOO_LONG     = 3'd1,
    ST_NUL          = 3'd2,
    ST_CONTROL      = 3'd3,
    ST_TOO_MANY     = 3'd4,
    ST_ARG_LONG     = 3'd5,
    ST_UNTERMINATED = 3'd6,
    ST_EMPTY        = 3'd7
  } status_e;

  typedef struct packed {
    kind_e                kind;
    logic [7:0]           out_byte;
    logic [PEND_W-1:0]    run_length;
    status_e              status;
    logic [ARGCNT_W-1:0]  arg_total;
    logic                 last_of_run;
  } res_t;

  typedef struct packed {
    logic                  inside_arg;
    logic                  quoting;
    logic                  saw_quote_or_char;
    logic [PEND_W-1:0]     pend_bs;
    logic [ARGLEN_W-1:0]   arg_len;
    logic [ARGCNT_W-1:0]   arg_cnt;
    logic [BYTECNT_W-1:0]  byte_cnt;
    status_e               first_err;
    logic                  saw_nul;
  } state_t;

  localparam state_t STATE_RESET = '{
    inside_arg:        1'b0,
    quoting:           1'b0,
    saw_quote_or_char: 1'b0,
    pend_bs:           '0,
    arg_len:           '0,
    arg_cnt:           '0,
    byte_cnt:          '0,
    first_err:         ST_OK,
    saw_nul:           1'b0
  };

endpackage

// ===== hw/rtl/cmdtok_step.sv =====
// ----------------------------------------------------------------------------
// cmdtok_step
// next parser state and the group of results caused by one command item
// ----------------------------------------------------------------------------
module cmdtok_step (
  input  cmdtok_pkg::state_t                        st_i,
  input  logic [7:0]                                byte_i,
  input  logic                                      has_i,
  input  logic                                      last_i,
  output cmdtok_pkg::state_t                        st_o,
  output cmdtok_pkg::res_t [cmdtok_pkg::NRES-1:0]   res_o,
  output logic [cmdtok_pkg::CNT_W-1:0]              cnt_o
);

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_BSL   = 8'h5c;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
  endfunction

  function automatic logic [cmdtok_pkg::ARGLEN_W-1:0] grow(
    input logic [cmdtok_pkg::ARGLEN_W-1:0] len,
    input logic [cmdtok_pkg::PEND_W-1:0]   k
  );
    logic [cmdtok_pkg::ARGLEN_W:0] sum;
    sum = {1'b0, len} + (cmdtok_pkg::ARGLEN_W + 1)'(k);
    return sum[cmdtok_pkg::ARGLEN_W] ? '1 : sum[cmdtok_pkg::ARGLEN_W-1:0];
  endfunction

  function automatic cmdtok_pkg::res_t mk(
    input cmdtok_pkg::kind_e              kind,
    input logic [7:0]                     b,
    input logic [cmdtok_pkg::PEND_W-1:0]  len,
    input cmdtok_pkg::status_e            status,
    input logic [cmdtok_pkg::ARGCNT_W-1:0] total
  );
    cmdtok_pkg::res_t r;
    r.kind        = kind;
    r.out_byte    = b;
    r.run_length  = len;
    r.status      = status;
    r.arg_total   = total;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  always_comb begin
    cmdtok_pkg::state_t                       s;
    cmdtok_pkg::res_t [cmdtok_pkg::NRES-1:0]  r;
    logic [cmdtok_pkg::CNT_W-1:0]             n;
    logic                                     go;
    logic                                     odd;
    logic [cmdtok_pkg::PEND_W-1:0]            half;
    logic [cmdtok_pkg::IDX_W-1:0]             tail;
    cmdtok_pkg::status_e                      st;

    s    = st_i;
    r    = '0;
    n    = '0;
    go   = 1'b0;
    odd  = 1'b0;
    half = '0;
    tail = '0;
    st   = cmdtok_pkg::ST_OK;

    if (has_i) begin
      if (s.byte_cnt <= cmdtok_pkg::BYTECNT_W'(cmdtok_pkg::MAX_COMMAND_BYTES)) begin
        s.byte_cnt = s.byte_cnt + 1'b1;
      end
      if (byte_i == CHAR_NUL) begin
        s.saw_nul = 1'b1;
      end

      if (s.first_err == cmdtok_pkg::ST_OK) begin
        go = 1'b1;
        // opening a new argument
        if (!s.inside_arg) begin
          if (is_blank(byte_i)) begin
            go = 1'b0;
          end else if (s.arg_cnt >= cmdtok_pkg::ARGCNT_W'(cmdtok_pkg::MAX_ARGS)) begin
            s.first_err = cmdtok_pkg::ST_TOO_MANY;
            go          = 1'b0;
          end else begin
            s.inside_arg        = 1'b1;
            s.quoting           = 1'b0;
            s.saw_quote_or_char = 1'b0;
            s.pend_bs           = '0;
            s.arg_len           = '0;
          end
        end

        if (go) begin
          if (byte_i == CHAR_BSL) begin
            if (s.pend_bs != '1) begin
              s.pend_bs = s.pend_bs + 1'b1;
            end
          end else if (byte_i == CHAR_QUOTE) begin
            // half the backslashes survive, an odd one escapes the quote
            odd  = s.pend_bs[0];
            half = s.pend_bs >> 1;
            if (half != '0) begin
              if (n < cmdtok_pkg::CNT_W'(cmdtok_pkg::NRES)) begin
                r[n[cmdtok_pkg::IDX_W-1:0]] = mk(cmdtok_pkg::KIND_RUN, CHAR_BSL, half,
                                                 cmdtok_pkg::ST_OK, '0);
                n = n + 1'b1;
              end
              s.arg_len = grow(s.arg_len, half);
            end
            s.pend_bs = '0;
            if (odd) begin
              if (n < cmdtok_pkg::CNT_W'(cmdtok_pkg::NRES)) begin
                r[n[cmdtok_pkg::IDX_W-1:0]] = mk(cmdtok_pkg::KIND_RUN, CHAR_QUOTE,
                                                 cmdtok_pkg::PEND_W'(1),
                                                 cmdtok_pkg::ST_OK, '0);
                n = n + 1'b1;
              end
              s.arg_len = grow(s.arg_len, cmdtok_pkg::PEND_W'(1));
            end else begin
              s.quoting = !s.quoting;
            end
            s.saw_quote_or_char = 1'b1;
          end else begin
            if (s.pend_bs != '0) begin
              if (n < cmdtok_pkg::CNT_W'(cmdtok_pkg::NRES)) begin
                r[n[cmdtok_pkg::IDX_W-1:0]] = mk(cmdtok_pkg::KIND_RUN, CHAR_BSL, s.pend_bs,
                                                 cmdtok_pkg::ST_OK, '0);
                n = n + 1'b1;
              end
              s.arg_len = grow(s.arg_len, s.pend_bs);
            end
            s.pend_bs = '0;

            if (!s.quoting && is_blank(byte_i)) begin
              // whitespace closes the argument
              if (s.quoting) begin
                s.first_err = cmdtok_pkg::ST_UNTERMINATED;
              end else if (!s.saw_quote_or_char && (s.arg_len == '0)) begin
                s.first_err = cmdtok_pkg::ST_EMPTY;
              end else begin
                if (n < cmdtok_pkg::CNT_W'(cmdtok_pkg::NRES)) begin
                  r[n[cmdtok_pkg::IDX_W-1:0]] = mk(cmdtok_pkg::KIND_END, '0, '0,
                                                   cmdtok_pkg::ST_OK, '0);
                  n = n + 1'b1;
                end
                s.arg_cnt    = s.arg_cnt + 1'b1;
                s.inside_arg = 1'b0;
              end
            end else if (byte_i < CHAR_SPACE) begin
              s.first_err = cmdtok_pkg::ST_CONTROL;
            end else begin
              if (n < cmdtok_pkg::CNT_W'(cmdtok_pkg::NRES)) begin
                r[n[cmdtok_pkg::IDX_W-1:0]] = mk(cmdtok_pkg::KIND_RUN, byte_i,
                                                 cmdtok_pkg::PEND_W'(1),
                                                 cmdtok_pkg::ST_OK, '0);
                n = n + 1'b1;
              end
              s.arg_len           = grow(s.arg_len, cmdtok_pkg::PEND_W'(1));
              s.saw_quote_or_char = 1'b1;
              if (s.arg_len > cmdtok_pkg::ARGLEN_W'(cmdtok_pkg::MAX_ARG_BYTES)) begin
                s.first_err = cmdtok_pkg::ST_ARG_LONG;
              end
            end
          end
        end
      end
    end

    if (last_i) begin
      // end of command closes an open argument
      if ((s.first_err == cmdtok_pkg::ST_OK) && s.inside_arg) begin
        if (s.pend_bs != '0) begin
          if (n < cmdtok_pkg::CNT_W'(cmdtok_pkg::NRES)) begin
            r[n[cmdtok_pkg::IDX_W-1:0]] = mk(cmdtok_pkg::KIND_RUN, CHAR_BSL, s.pend_bs,
                                             cmdtok_pkg::ST_OK, '0);
            n = n + 1'b1;
          end
          s.arg_len = grow(s.arg_len, s.pend_bs);
        end
        s.pend_bs = '0;
        if (s.quoting) begin
          s.first_err = cmdtok_pkg::ST_UNTERMINATED;
        end else if (!s.saw_quote_or_char && (s.arg_len == '0)) begin
          s.first_err = cmdtok_pkg::ST_EMPTY;
        end else begin
          if (n < cmdtok_pkg::CNT_W'(cmdtok_pkg::NRES)) begin
            r[n[cmdtok_pkg::IDX_W-1:0]] = mk(cmdtok_pkg::KIND_END, '0, '0,
                                             cmdtok_pkg::ST_OK, '0);
            n = n + 1'b1;
          end
          s.arg_cnt    = s.arg_cnt + 1'b1;
          s.inside_arg = 1'b0;
        end
      end

      if (s.byte_cnt > cmdtok_pkg::BYTECNT_W'(cmdtok_pkg::MAX_COMMAND_BYTES)) begin
        st = cmdtok_pkg::ST_TOO_LONG;
      end else if (s.saw_nul) begin
        st = cmdtok_pkg::ST_NUL;
      end else begin
        st = s.first_err;
      end
      if (n < cmdtok_pkg::CNT_W'(cmdtok_pkg::NRES)) begin
        r[n[cmdtok_pkg::IDX_W-1:0]] = mk((st == cmdtok_pkg::ST_OK) ? cmdtok_pkg::KIND_ACCEPT
                                                                   : cmdtok_pkg::KIND_REJECT,
                                         '0, '0, st, s.arg_cnt);
        n = n + 1'b1;
      end
      s = cmdtok_pkg::STATE_RESET;
    end

    if (n != '0) begin
      tail                = n[cmdtok_pkg::IDX_W-1:0] - 1'b1;
      r[tail].last_of_run = 1'b1;
    end

    st_o  = s;
    res_o = r;
    cnt_o = n;
  end

endmodule

// ===== hw/rtl/command_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// command_line_tokenizer
// splits a byte stream into arguments under windows quoting rules
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                     tuser      tlast
//  s_axis   in   in_byte                                   has_byte   last
//  m_axis   out  out_byte, run_length, status, arg_total   kind       last_of_run
//
//  an item is registered at the input, then parsed combinationally into a
//  registered group of up to four results
//  an item causing k results (k >= 1) occupies the result group until its last
//  result is taken; items of at most one result stream at one per cycle,
//  and results drain one per cycle through m_axis, while m_axis_tready is high
//  reset is asynchronous and clears parser state, input and group valids
//  a stall on m_axis backs up through the group and input registers
// ----------------------------------------------------------------------------
module command_line_tokenizer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [7:0] in_byte
  input  logic [cmdtok_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] has_byte
  input  logic [0:0]                         s_axis_tuser,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [7:0] out_byte, [22:8] run_length, [25:23] status, [33:26] arg_total
  output logic [cmdtok_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // [1:0] kind
  output logic [1:0]                         m_axis_tuser,
  output logic                               m_axis_tlast
);

  // input register
  logic                                     in_vld_q;
  logic [7:0]                               in_byte_q;
  logic                                     in_has_q;
  logic                                     in_last_q;

  // parser state and result group
  cmdtok_pkg::state_t                       st_q;
  cmdtok_pkg::state_t                       st_d;
  cmdtok_pkg::res_t [cmdtok_pkg::NRES-1:0]  grp_q;
  cmdtok_pkg::res_t [cmdtok_pkg::NRES-1:0]  grp_d;
  logic [cmdtok_pkg::CNT_W-1:0]             grp_cnt_q;
  logic [cmdtok_pkg::CNT_W-1:0]             grp_cnt_d;

  logic                                     grp_free;
  logic                                     load;
  logic                                     take;
  cmdtok_pkg::res_t                         head;

  cmdtok_step u_step (
    .st_i   (st_q),
    .byte_i (in_byte_q),
    .has_i  (in_has_q),
    .last_i (in_last_q),
    .st_o   (st_d),
    .res_o  (grp_d),
    .cnt_o  (grp_cnt_d)
  );

  assign take          = m_axis_tvalid && m_axis_tready;
  assign grp_free      = (grp_cnt_q == '0) ||
                         ((grp_cnt_q == cmdtok_pkg::CNT_W'(1)) && m_axis_tready);
  assign load          = in_vld_q && grp_free;
  assign s_axis_tready = !in_vld_q || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata[7:0];
      in_has_q  <= s_axis_tuser[0];
      in_last_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= cmdtok_pkg::STATE_RESET;
      grp_cnt_q <= '0;
    end else if (load) begin
      st_q      <= st_d;
      grp_cnt_q <= grp_cnt_d;
    end else if (take) begin
      grp_cnt_q <= grp_cnt_q - 1'b1;
    end
  end

  // the group shifts down as results leave, head is always slot zero
  always_ff @(posedge clk_i) begin
    if (load) begin
      grp_q <= grp_d;
    end else if (take) begin
      for (int i = 0; i < cmdtok_pkg::NRES - 1; i++) begin
        grp_q[i] <= grp_q[i+1];
      end
    end
  end

  assign head          = grp_q[0];
  assign m_axis_tvalid = (grp_cnt_q != '0);
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last_of_run;
  assign m_axis_tdata  = {6'b0, head.arg_total, head.status, head.run_length, head.out_byte};

`ifndef NO_ASSERTIONS
  a_grp_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_cnt_q <= cmdtok_pkg::CNT_W'(cmdtok_pkg::NRES))
    else $error("result group count out of range");

  a_last_gives_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && in_last_q |=> m_axis_tvalid)
    else $error("final item produced no status result");

  a_last_resets_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && in_last_q |=> st_q == cmdtok_pkg::STATE_RESET)
    else $error("parser state not cleared after final item");

  a_tlast_on_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (grp_cnt_q == cmdtok_pkg::CNT_W'(1))))
    else $error("last_of_run not on the final result of the group");

  a_no_load_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && m_axis_tvalid |-> take && m_axis_tlast)
    else $error("group overwritten before drained");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the command line tokenizer against a cycle-free predictor: whole
// commands are streamed in, every result item is compared field by field
// in order, under several sender and receiver idling phases
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 240;
  localparam int DRAIN_CYCLES = 20;
  localparam int TIMEOUT_NS   = 5_000_000;

  localparam int unsigned PEND_CAP   = 32767;
  localparam int unsigned ARGLEN_CAP = 65535;

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_A         = 8'h61;
  localparam logic [7:0] CH_SOH       = 8'h01;
  localparam logic [7:0] CH_HIGH      = 8'hFF;

  typedef struct packed {
    logic [7:0] b;
    logic       has;
    logic       fin;
  } cmd_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                               s_valid = 1'b0;
  logic [cmdtok_pkg::IN_TDATA_W-1:0]  s_data  = '0;
  logic [0:0]                         s_user  = '0;
  logic                               s_last  = 1'b0;
  logic                               s_ready;
  logic                               m_valid;
  logic                               m_ready = 1'b0;
  logic [cmdtok_pkg::OUT_TDATA_W-1:0] m_data;
  logic [1:0]                         m_user;
  logic                               m_last;

  logic s_fire = 1'b0;
  int   send_idle  = 0;
  int   recv_stall = 0;
  int   n_errors   = 0;
  int   n_results  = 0;
  int   queued_items = 0;

  cmd_item_t          send_q[$];
  cmdtok_pkg::res_t   expected_results[$];

  // predictor state
  logic                 in_arg   = 1'b0;
  logic                 quoting  = 1'b0;
  logic                 seen_qc  = 1'b0;
  int unsigned          pend_bs  = 0;
  int unsigned          arg_len  = 0;
  logic [7:0]           arg_cnt  = '0;
  int unsigned          byte_cnt = 0;
  cmdtok_pkg::status_e  first_err = cmdtok_pkg::ST_OK;
  logic                 saw_nul  = 1'b0;
  cmdtok_pkg::res_t     step_res[cmdtok_pkg::NRES];
  int                   step_n;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  command_line_tokenizer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    // [7:0] in_byte
    .s_axis_tdata  (s_data),
    // [0] has_byte
    .s_axis_tuser  (s_user),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    // [7:0] out_byte, [22:8] run_length, [25:23] status, [33:26] arg_total
    .m_axis_tdata  (m_data),
    // [1:0] kind
    .m_axis_tuser  (m_user),
    .m_axis_tlast  (m_last)
  );

  task automatic flag_error(input string what);
    $display("ERROR @%0t result %0d: %s", $time, n_results, what);
    n_errors++;
  endtask

  function automatic logic is_blank(input logic [7:0] b);
    return b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  task automatic add_result(input cmdtok_pkg::kind_e k, input logic [7:0] b,
                            input int unsigned len, input cmdtok_pkg::status_e st,
                            input logic [7:0] tot);
    if (step_n < cmdtok_pkg::NRES) begin
      step_res[step_n] = '{kind: k, out_byte: b, run_length: len[cmdtok_pkg::PEND_W-1:0],
                           status: st, arg_total: tot, last_of_run: 1'b0};
      step_n++;
    end
  endtask

  task automatic grow_len(input int unsigned k);
    arg_len = (arg_len + k > ARGLEN_CAP) ? ARGLEN_CAP : arg_len + k;
  endtask

  task automatic flush_bs(input int unsigned cnt);
    if (cnt > 0) begin
      add_result(cmdtok_pkg::KIND_RUN, CH_BACKSLASH, cnt, cmdtok_pkg::ST_OK, '0);
      grow_len(cnt);
    end
    pend_bs = 0;
  endtask

  task automatic close_arg();
    if (quoting) begin
      first_err = cmdtok_pkg::ST_UNTERMINATED;
    end else if (!seen_qc && arg_len == 0) begin
      first_err = cmdtok_pkg::ST_EMPTY;
    end else begin
      add_result(cmdtok_pkg::KIND_END, '0, 0, cmdtok_pkg::ST_OK, '0);
      arg_cnt = arg_cnt + 8'd1;
      in_arg  = 1'b0;
    end
  endtask

  // works out the results of one accepted item and queues them
  task automatic tokenize_item(input logic [7:0] b, input logic has, input logic fin);
    logic                odd;
    cmdtok_pkg::status_e st;
    step_n = 0;
    if (has) begin
      if (byte_cnt <= cmdtok_pkg::MAX_COMMAND_BYTES) byte_cnt++;
      if (b == CH_NUL) saw_nul = 1'b1;
      if (first_err == cmdtok_pkg::ST_OK) begin
        if (!in_arg && !is_blank(b)) begin
          if (arg_cnt >= cmdtok_pkg::MAX_ARGS) begin
            first_err = cmdtok_pkg::ST_TOO_MANY;
          end else begin
            in_arg  = 1'b1;
            quoting = 1'b0;
            seen_qc = 1'b0;
            pend_bs = 0;
            arg_len = 0;
          end
        end
        if (in_arg) begin
          if (b == CH_BACKSLASH) begin
            if (pend_bs < PEND_CAP) pend_bs++;
          end else if (b == CH_QUOTE) begin
            odd = (pend_bs % 2) != 0;
            flush_bs(pend_bs >> 1);
            if (odd) begin
              add_result(cmdtok_pkg::KIND_RUN, CH_QUOTE, 1, cmdtok_pkg::ST_OK, '0);
              grow_len(1);
            end else begin
              quoting = !quoting;
            end
            seen_qc = 1'b1;
          end else begin
            flush_bs(pend_bs);
            if (!quoting && is_blank(b)) begin
              close_arg();
            end else if (b < CH_SPACE) begin
              first_err = cmdtok_pkg::ST_CONTROL;
            end else begin
              add_result(cmdtok_pkg::KIND_RUN, b, 1, cmdtok_pkg::ST_OK, '0);
              grow_len(1);
              seen_qc = 1'b1;
              if (arg_len > cmdtok_pkg::MAX_ARG_BYTES) first_err = cmdtok_pkg::ST_ARG_LONG;
            end
          end
        end
      end
    end
    if (fin) begin
      if (first_err == cmdtok_pkg::ST_OK && in_arg) begin
        flush_bs(pend_bs);
        close_arg();
      end
      // too long beats nul, which beats any parse error
      if (byte_cnt > cmdtok_pkg::MAX_COMMAND_BYTES) st = cmdtok_pkg::ST_TOO_LONG;
      else if (saw_nul) st = cmdtok_pkg::ST_NUL;
      else st = first_err;
      add_result((st == cmdtok_pkg::ST_OK) ? cmdtok_pkg::KIND_ACCEPT : cmdtok_pkg::KIND_REJECT,
                 '0, 0, st, arg_cnt);
      in_arg    = 1'b0;
      quoting   = 1'b0;
      seen_qc   = 1'b0;
      pend_bs   = 0;
      arg_len   = 0;
      arg_cnt   = '0;
      byte_cnt  = 0;
      first_err = cmdtok_pkg::ST_OK;
      saw_nul   = 1'b0;
    end
    for (int i = 0; i < step_n; i++) begin
      if (i == step_n - 1) step_res[i].last_of_run = 1'b1;
      expected_results = {expected_results, step_res[i]};
    end
  endtask

  // driver: presents the next pending item once the current one is taken
  always @(negedge clk_i) begin : drive
    cmd_item_t it;
    if (rst_ni) begin
      if (!s_valid || s_fire) begin
        if (send_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          it = send_q.pop_front();
          s_valid <= 1'b1;
          s_data  <= it.b;
          s_user  <= it.has;
          s_last  <= it.fin;
        end else begin
          s_valid <= 1'b0;
        end
      end
      m_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // monitor: checks result items, and feeds accepted items to the predictor
  always @(posedge clk_i) begin : observe
    cmdtok_pkg::res_t want;
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        if (expected_results.size() == 0) begin
          flag_error("result with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (m_user != want.kind)
            flag_error($sformatf("kind %0d, expected %0d", m_user, want.kind));
          if (m_data[7:0] != want.out_byte)
            flag_error($sformatf("out_byte %0h, expected %0h", m_data[7:0], want.out_byte));
          if (m_data[22:8] != want.run_length)
            flag_error($sformatf("run_length %0d, expected %0d", m_data[22:8],
                                 want.run_length));
          if (m_data[25:23] != want.status)
            flag_error($sformatf("status %0d, expected %0d", m_data[25:23], want.status));
          if (m_data[33:26] != want.arg_total)
            flag_error($sformatf("arg_total %0d, expected %0d", m_data[33:26],
                                 want.arg_total));
          if (m_last != want.last_of_run)
            flag_error($sformatf("last_of_run %0b, expected %0b", m_last,
                                 want.last_of_run));
        end
        n_results++;
      end
      if (s_valid && s_ready) tokenize_item(s_data, s_user[0], s_last);
    end
    s_fire <= s_valid && s_ready;
  end

  task automatic push_item(input logic [7:0] b, input logic has, input logic fin);
    cmd_item_t it;
    it = '{b: b, has: has, fin: fin};
    send_q = {send_q, it};
    if (has || fin) queued_items++;
  endtask

  task automatic push_text(input string s, input logic fin_at_end);
    for (int i = 0; i < s.len(); i++) push_item(s[i], 1'b1, fin_at_end && i == s.len() - 1);
  endtask

  function automatic logic [7:0] rand_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(8'hFF, 8'h21)); while (b == CH_QUOTE || b == CH_BACKSLASH);
    return b;
  endfunction

  function automatic logic [7:0] rand_blank();
    int unsigned r;
    r = $urandom_range(5);
    return (r == 5) ? CH_SPACE : 8'(CH_TAB + r);
  endfunction

  // mostly well-formed commands with random content, some noise and broken quoting
  task automatic queue_random_commands(input int n_items);
    int start;
    int sel;
    int nargs;
    int ntok;
    start = queued_items;
    while (queued_items - start < n_items) begin
      sel = $urandom_range(99);
      if (sel < 10) begin
        repeat ($urandom_range(10, 1))
          push_item(8'($urandom), ($urandom_range(7) != 0), 1'b0);
      end else if (sel >= 14) begin
        nargs = $urandom_range(4);
        for (int a = 0; a < nargs; a++) begin
          repeat ($urandom_range(2, (a == 0) ? 0 : 1)) push_item(rand_blank(), 1'b1, 1'b0);
          ntok = $urandom_range(4, 1);
          for (int t = 0; t < ntok; t++) begin
            // an idle item with a junk byte now and then
            if ($urandom_range(19) == 0) push_item(8'($urandom), 1'b0, 1'b0);
            case ($urandom_range(3))
              0: repeat ($urandom_range(3, 1)) push_item(rand_plain(), 1'b1, 1'b0);
              1: begin
                push_item(CH_QUOTE, 1'b1, 1'b0);
                repeat ($urandom_range(4))
                  push_item($urandom_range(1) ? rand_plain() : CH_SPACE, 1'b1, 1'b0);
                if ($urandom_range(19) != 0) push_item(CH_QUOTE, 1'b1, 1'b0);
              end
              2: begin
                repeat ($urandom_range(5, 1)) push_item(CH_BACKSLASH, 1'b1, 1'b0);
                push_item($urandom_range(1) ? CH_QUOTE : rand_plain(), 1'b1, 1'b0);
              end
              default: begin
                if ($urandom_range(9) == 0) push_item(8'($urandom_range(8'h1F)), 1'b1, 1'b0);
                else push_item(rand_plain(), 1'b1, 1'b0);
              end
            endcase
          end
        end
        if ($urandom_range(1)) push_item(rand_blank(), 1'b1, 1'b0);
      end
      // close on the last byte, or with a separate byteless item
      if (send_q.size() > 0 && send_q[send_q.size() - 1].has &&
          !send_q[send_q.size() - 1].fin && $urandom_range(1)) begin
        send_q[send_q.size() - 1].fin = 1'b1;
      end else begin
        push_item(8'($urandom), 1'b0, 1'b1);
      end
    end
  endtask

  task automatic wait_quiet();
    while (send_q.size() != 0 || s_valid || expected_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty command
    push_item(CH_NUL, 1'b0, 1'b1);
    // quoted space, odd backslash run before a quote, trailing backslashes
    push_text("a\"b c\"\\\\\\\" d\\\\", 1'b0);
    push_item(CH_NUL, 1'b0, 1'b1);
    // even backslash run opens quoting, then a tab inside quotes
    push_text("\\\\\"\tu", 1'b1);
    // top byte, a byteless item mid-command, then nul
    push_item(CH_HIGH, 1'b1, 1'b0);
    push_item(CH_NUL, 1'b0, 1'b0);
    push_item(CH_NUL, 1'b1, 1'b1);
    // unterminated quote
    push_text("\"z", 1'b1);
    // control byte outside quotes
    push_item(CH_SOH, 1'b1, 1'b1);

    // argument count one beyond the limit
    repeat (cmdtok_pkg::MAX_ARGS + 1) begin
      push_item(CH_A, 1'b1, 1'b0);
      push_item(CH_SPACE, 1'b1, 1'b0);
    end
    push_item(CH_NUL, 1'b0, 1'b1);
    wait_quiet();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 76; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 76; end
        default: begin send_idle = 37; recv_stall = 37; end
      endcase
      queue_random_commands(RANDOM_ITEMS / 4);
      wait_quiet();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0)
      flag_error($sformatf("%0d expected results never arrived", expected_results.size()));
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/cmdtok_pkg.sv
hw/rtl/cmdtok_step.sv
hw/rtl/command_line_tokenizer.sv
tb/sv/tb_top.sv
